// ===== src/bpe_pkg.sv =====
// Shared types and constants for the byte pair dictionary expander.
package bpe_pkg;

    localparam logic [7:0] TERMINATOR = 8'hF0;
    localparam int         WALK_LIMIT = 4096;
    localparam int         POP_W      = $clog2(WALK_LIMIT + 1);
    localparam int         LEN_W      = 3;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_EXPAND = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_TERM = 2'd1,
        ST_CAP  = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    typedef struct packed {
        logic             is_pair;
        logic [LEN_W-1:0] len;
        logic [31:0]      value;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_VISIT,
        S_ENTRY,
        S_LEAF,
        S_NEXT,
        S_POP
    } state_t;

    typedef struct packed {
        logic    load_entry;
        logic    init_walk;
        logic    visit;
        logic    latch_leaf;
        logic    push_pair;
        logic    emit_byte;
        logic    pop_issue;
        logic    pop_load;
        logic    finish;
        status_t fin_status;
    } cmd_t;

    typedef struct packed {
        logic start_load;
        logic start_term;
        logic limit_hit;
        logic cur_live;
        logic is_pair;
        logic overflow;
        logic leaf_more;
        logic cap_hit;
        logic stack_empty;
    } stat_t;

endpackage

// ===== src/bpe_dictionary_expander.sv =====
// Top level of the byte pair dictionary expander.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  input   | start, busy           | action, code, entry_is_pair, entry_length,
//          |                       | entry_value
//  result  | strobe (one cycle)    | out_byte, has_byte, last, status
//
// A load completes with its transfer and keeps busy low. An expand visits pair nodes,
// unused codes, leaves (one byte per cycle) and pops; a cyclic dictionary is cut off
// after WALK_LIMIT visits.
// A byte is held back until the next is taken or the walk ends, so last and status can
// join it; the final result shows in the first cycle with busy low, and a terminator
// expand keeps busy low and answers the cycle after its transfer.
// Reset clears the entry used bits at once; no clearing pass. Results cannot be stalled.
module bpe_dictionary_expander #(
    parameter int NUM_CODES   = 240,
    parameter int LEAF_BYTES  = 4,
    parameter int STACK_DEPTH = 16,
    parameter int MAX_OUT     = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [7:0]  code,
    input  logic        entry_is_pair,
    input  logic [2:0]  entry_length,
    input  logic [31:0] entry_value,
    output logic        strobe,
    output logic [7:0]  out_byte,
    output logic        has_byte,
    output logic        last,
    output logic [1:0]  status
);
    import bpe_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    bpe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    bpe_datapath #(
        .NUM_CODES   (NUM_CODES),
        .LEAF_BYTES  (LEAF_BYTES),
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_OUT     (MAX_OUT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .action        (action),
        .code          (code),
        .entry_is_pair (entry_is_pair),
        .entry_length  (entry_length),
        .entry_value   (entry_value),
        .cmd           (cmd),
        .stat          (stat),
        .strobe        (strobe),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .last          (last),
        .status        (status)
    );

    // a result that is not the last always carries a byte
    a_mid_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> has_byte)
        else $error("non-final result without a byte");

    // non-zero status only on the final transfer
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ST_OK) |-> last)
        else $error("status on a non-final result");

    // the walk is still going while a non-final byte is out
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("walk ended with a byte still held back");

    a_emit_finish_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.emit_byte && cmd.finish))
        else $error("emit and finish in the same cycle");

endmodule

// ===== src/bpe_ram.sv =====
// Generic single write port RAM with registered read.
module bpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/bpe_ctrl.sv =====
// Walk controller: sequences loads, tree visits, leaf byte output and stack pops.
module bpe_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  bpe_pkg::stat_t stat,
    output bpe_pkg::cmd_t  cmd,
    output logic          busy
);
    import bpe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !stat.start_load && !stat.start_term)
                begin
                    state_next = S_VISIT;
                end
            end
            S_VISIT:
            begin
                if (stat.limit_hit)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.cur_live)
                begin
                    state_next = S_ENTRY;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_ENTRY:
            begin
                if (stat.is_pair)
                begin
                    state_next = stat.overflow ? S_IDLE : S_VISIT;
                end
                else
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                if (stat.leaf_more)
                begin
                    state_next = stat.cap_hit ? S_IDLE : S_LEAF;
                end
                else
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                state_next = stat.stack_empty ? S_IDLE : S_POP;
            end
            S_POP:
            begin
                state_next = S_VISIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.fin_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (stat.start_load)
                    begin
                        cmd.load_entry = 1'b1;
                    end
                    else if (stat.start_term)
                    begin
                        cmd.init_walk  = 1'b1;
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_TERM;
                    end
                    else
                    begin
                        cmd.init_walk = 1'b1;
                    end
                end
            end
            S_VISIT:
            begin
                if (stat.limit_hit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_OVF;
                end
                else
                begin
                    cmd.visit = 1'b1;
                end
            end
            S_ENTRY:
            begin
                if (!stat.is_pair)
                begin
                    cmd.latch_leaf = 1'b1;
                end
                else if (stat.overflow)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_OVF;
                end
                else
                begin
                    cmd.push_pair = 1'b1;
                end
            end
            S_LEAF:
            begin
                if (stat.leaf_more)
                begin
                    if (stat.cap_hit)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_CAP;
                    end
                    else
                    begin
                        cmd.emit_byte = 1'b1;
                    end
                end
            end
            S_NEXT:
            begin
                if (stat.stack_empty)
                begin
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.pop_issue = 1'b1;
                end
            end
            S_POP:
            begin
                cmd.pop_load = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== src/bpe_datapath.sv =====
// Datapath: code table, walk stack, counters, held-back byte and result registers.
module bpe_datapath #(
    parameter int NUM_CODES   = 240,
    parameter int LEAF_BYTES  = 4,
    parameter int STACK_DEPTH = 16,
    parameter int MAX_OUT     = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           action,
    input  logic [7:0]     code,
    input  logic           entry_is_pair,
    input  logic [2:0]     entry_length,
    input  logic [31:0]    entry_value,
    input  bpe_pkg::cmd_t  cmd,
    output bpe_pkg::stat_t stat,
    output logic           strobe,
    output logic [7:0]     out_byte,
    output logic           has_byte,
    output logic           last,
    output logic [1:0]     status
);
    import bpe_pkg::*;

    localparam int CODE_AW = $clog2(NUM_CODES);
    localparam int SP_AW   = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int EMIT_W  = $clog2(MAX_OUT + 1);

    // control state
    logic [NUM_CODES-1:0] used_reg, used_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [POP_W-1:0]     pops_reg, pops_next;
    logic [EMIT_W-1:0]    emit_reg, emit_next;
    logic                 pend_v_reg, pend_v_next;
    logic                 strobe_reg, strobe_next;

    // payload
    logic [7:0]       cur_reg, cur_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic [31:0]      leaf_val_reg, leaf_val_next;
    logic [LEN_W-1:0] leaf_len_reg, leaf_len_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             has_byte_reg, has_byte_next;
    logic             last_reg, last_next;
    status_t          status_reg, status_next;

    entry_t           tab_wdata;
    entry_t           tab_q;
    logic [7:0]       stack_q;
    logic             tab_we;
    logic [LEN_W-1:0] len_sat;
    logic [7:0]       byte_now;
    logic [SP_W-1:0]  sp_dec;

    assign len_sat = (entry_length > LEN_W'(LEAF_BYTES)) ? LEN_W'(LEAF_BYTES) : entry_length;
    assign tab_wdata.is_pair = entry_is_pair;
    assign tab_wdata.len     = len_sat;
    assign tab_wdata.value   = entry_value;
    assign tab_we   = cmd.load_entry && (code < 8'(NUM_CODES));
    assign byte_now = leaf_val_reg[{idx_reg[1:0], 3'b000} +: 8];
    assign sp_dec   = sp_reg - SP_W'(1);

    bpe_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_CODES)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (code[CODE_AW-1:0]),
        .wdata (tab_wdata),
        .re    (cmd.visit),
        .raddr (cur_reg[CODE_AW-1:0]),
        .rdata (tab_q)
    );

    // right half goes on the stack, left half is visited straight away
    bpe_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push_pair),
        .waddr (sp_reg[SP_AW-1:0]),
        .wdata (tab_q.value[15:8]),
        .re    (cmd.pop_issue),
        .raddr (sp_dec[SP_AW-1:0]),
        .rdata (stack_q)
    );

    always_comb
    begin
        stat.start_load  = (action == ACT_LOAD);
        stat.start_term  = (code >= TERMINATOR);
        stat.limit_hit   = (pops_reg == POP_W'(WALK_LIMIT));
        stat.cur_live    = (cur_reg < 8'(NUM_CODES)) && (cur_reg < TERMINATOR)
                           && used_reg[cur_reg[CODE_AW-1:0]];
        stat.is_pair     = tab_q.is_pair;
        stat.overflow    = ({1'b0, sp_reg} + (SP_W+1)'(2)) > (SP_W+1)'(STACK_DEPTH);
        stat.leaf_more   = (idx_reg < leaf_len_reg);
        stat.cap_hit     = (emit_reg >= EMIT_W'(MAX_OUT));
        stat.stack_empty = (sp_reg == '0);
    end

    always_comb
    begin
        used_next      = used_reg;
        sp_next        = sp_reg;
        pops_next      = pops_reg;
        emit_next      = emit_reg;
        pend_v_next    = pend_v_reg;
        strobe_next    = 1'b0;
        cur_next       = cur_reg;
        pend_byte_next = pend_byte_reg;
        leaf_val_next  = leaf_val_reg;
        leaf_len_next  = leaf_len_reg;
        idx_next       = idx_reg;
        out_byte_next  = out_byte_reg;
        has_byte_next  = has_byte_reg;
        last_next      = last_reg;
        status_next    = status_reg;

        if (tab_we)
        begin
            used_next[code[CODE_AW-1:0]] = 1'b1;
        end
        if (cmd.init_walk)
        begin
            cur_next    = code;
            sp_next     = '0;
            pops_next   = '0;
            emit_next   = '0;
            pend_v_next = 1'b0;
        end
        if (cmd.visit)
        begin
            pops_next = pops_reg + POP_W'(1);
        end
        if (cmd.latch_leaf)
        begin
            leaf_val_next = tab_q.value;
            leaf_len_next = tab_q.len;
            idx_next      = '0;
        end
        if (cmd.push_pair)
        begin
            sp_next  = sp_reg + SP_W'(1);
            cur_next = tab_q.value[7:0];
        end
        if (cmd.pop_issue)
        begin
            sp_next = sp_dec;
        end
        if (cmd.pop_load)
        begin
            cur_next = stack_q;
        end
        // a byte is held back one step so that last and status can join it
        if (cmd.emit_byte)
        begin
            if (pend_v_reg)
            begin
                strobe_next   = 1'b1;
                out_byte_next = pend_byte_reg;
                has_byte_next = 1'b1;
                last_next     = 1'b0;
                status_next   = ST_OK;
            end
            pend_byte_next = byte_now;
            pend_v_next    = 1'b1;
            emit_next      = emit_reg + EMIT_W'(1);
            idx_next       = idx_reg + LEN_W'(1);
        end
        if (cmd.finish)
        begin
            strobe_next   = 1'b1;
            out_byte_next = pend_v_next ? pend_byte_reg : 8'd0;
            has_byte_next = pend_v_next;
            last_next     = 1'b1;
            status_next   = cmd.fin_status;
            pend_v_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            sp_reg     <= '0;
            pops_reg   <= '0;
            emit_reg   <= '0;
            pend_v_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            sp_reg     <= sp_next;
            pops_reg   <= pops_next;
            emit_reg   <= emit_next;
            pend_v_reg <= pend_v_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        pend_byte_reg <= pend_byte_next;
        leaf_val_reg  <= leaf_val_next;
        leaf_len_reg  <= leaf_len_next;
        idx_reg       <= idx_next;
        out_byte_reg  <= out_byte_next;
        has_byte_reg  <= has_byte_next;
        last_reg      <= last_next;
        status_reg    <= status_next;
    end

    assign strobe   = strobe_reg;
    assign out_byte = out_byte_reg;
    assign has_byte = has_byte_reg;
    assign last     = last_reg;
    assign status   = status_reg;

endmodule

// ===== tb/sv/tb_bpe_dictionary_expander.sv =====
// Self-checking testbench for the byte pair dictionary expander.
`timescale 1ns / 100ps

module tb_bpe_dictionary_expander;

    import bpe_pkg::*;

    localparam int NUM_CODES    = 240;
    localparam int LEAF_BYTES   = 4;
    localparam int STACK_DEPTH  = 16;
    localparam int MAX_OUT      = 64;
    localparam int DICT_SPAN    = 32;
    localparam int RANDOM_ITEMS = 80;
    localparam int QUIET_LIMIT  = 60000;

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       is_last;
        status_t    st;
    } byte_result_t;

    typedef struct packed {
        logic         act;
        logic [7:0]   code;
        logic         pair;
        logic [2:0]   len;
        logic [31:0]  val;
        logic         typed;
        byte_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        action = ACT_LOAD;
    logic [7:0]  code = 8'h00;
    logic        entry_is_pair = 1'b0;
    logic [2:0]  entry_length = 3'd0;
    logic [31:0] entry_value = 32'h0;
    logic        strobe;
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        last;
    logic [1:0]  status;

    entry_t       dict [NUM_CODES];
    logic         dict_used [NUM_CODES];
    byte_result_t pending_bytes [$];
    byte_result_t due;
    stim_row_t    plan [$];
    int           errors = 0;
    int           quiet = 0;

    bpe_dictionary_expander #(
        .NUM_CODES   (NUM_CODES),
        .LEAF_BYTES  (LEAF_BYTES),
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_OUT     (MAX_OUT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .code          (code),
        .entry_is_pair (entry_is_pair),
        .entry_length  (entry_length),
        .entry_value   (entry_value),
        .strobe        (strobe),
        .out_byte      (out_byte),
        .has_byte      (has_byte),
        .last          (last),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void store_entry(input stim_row_t r);
        if (r.code < NUM_CODES)
        begin
            dict_used[r.code] = 1'b1;
            dict[r.code] = '{r.pair, (r.len > LEAF_BYTES) ? 3'(LEAF_BYTES) : r.len, r.val};
        end
    endfunction

    // Depth-first walk, left before right; queues the bytes one code expands to.
    function automatic void expand_code(input logic [7:0] root);
        logic [7:0]   stk [STACK_DEPTH];
        byte_result_t res [MAX_OUT];
        logic [7:0]   c;
        int           sp;
        int           n;
        int           pops;
        status_t      fin;
        bit           done;
        sp   = 1;
        n    = 0;
        pops = 0;
        fin  = ST_OK;
        done = 1'b0;
        stk[0] = root;
        if (root >= TERMINATOR)
        begin
            pending_bytes.push_back('{8'h00, 1'b0, 1'b1, ST_TERM});
            return;
        end
        while (sp > 0 && !done)
        begin
            if (pops >= WALK_LIMIT)
            begin
                fin  = ST_OVF;
                done = 1'b1;
            end
            else
            begin
                pops++;
                sp--;
                c = stk[sp];
                // unused and terminator constituents add nothing
                if (c < TERMINATOR && c < NUM_CODES && dict_used[c])
                begin
                    if (dict[c].is_pair)
                    begin
                        if (sp + 2 > STACK_DEPTH)
                        begin
                            fin  = ST_OVF;
                            done = 1'b1;
                        end
                        else
                        begin
                            stk[sp]     = dict[c].value[15:8];
                            stk[sp + 1] = dict[c].value[7:0];
                            sp += 2;
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < dict[c].len && !done; i++)
                        begin
                            if (n >= MAX_OUT)
                            begin
                                fin  = ST_CAP;
                                done = 1'b1;
                            end
                            else
                            begin
                                res[n] = '{dict[c].value[8*i +: 8], 1'b1, 1'b0, ST_OK};
                                n++;
                            end
                        end
                    end
                end
            end
        end
        if (n == 0)
            pending_bytes.push_back('{8'h00, 1'b0, 1'b1, fin});
        else
        begin
            res[n - 1].is_last = 1'b1;
            res[n - 1].st      = fin;
            for (int i = 0; i < n; i++)
                pending_bytes.push_back(res[i]);
        end
    endfunction

    function automatic stim_row_t load_row(input logic [7:0] c, input logic pair,
                                           input logic [2:0] len, input logic [31:0] val);
        stim_row_t r;
        r      = '0;
        r.act  = ACT_LOAD;
        r.code = c;
        r.pair = pair;
        r.len  = len;
        r.val  = val;
        return r;
    endfunction

    function automatic stim_row_t expand_row(input logic [7:0] c, input logic typed,
                                             input byte_result_t want);
        stim_row_t r;
        r       = '0;
        r.act   = ACT_EXPAND;
        r.code  = c;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Mostly well-formed entries in a small region, pairs pointing only at lower codes.
    function automatic stim_row_t random_row();
        stim_row_t r;
        int        roll;
        roll   = $urandom_range(99);
        r      = '0;
        r.act  = 1'($urandom_range(1));
        r.code = 8'($urandom_range(255));
        r.pair = 1'($urandom_range(1));
        r.len  = 3'($urandom_range(7));
        r.val  = $urandom;
        if (roll < 40)
        begin
            r.act  = ACT_LOAD;
            r.code = 8'($urandom_range(DICT_SPAN - 1));
            if (r.code == 0 || $urandom_range(1) == 0)
                r.pair = 1'b0;
            else
            begin
                r.pair       = 1'b1;
                r.val[7:0]   = 8'($urandom_range(r.code - 1));
                r.val[15:8]  = 8'($urandom_range(r.code - 1));
            end
        end
        else if (roll < 85)
        begin
            r.act  = ACT_EXPAND;
            r.code = 8'($urandom_range(DICT_SPAN - 1));
        end
        return r;
    endfunction

    task automatic maybe_idle();
        while ($urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic issue(input stim_row_t r);
        start         <= 1'b1;
        action        <= r.act;
        code          <= r.code;
        entry_is_pair <= r.pair;
        entry_length  <= r.len;
        entry_value   <= r.val;
        do
            @(posedge clk);
        while (busy);
        if (r.act == ACT_LOAD)
            store_entry(r);
        else if (r.typed)
            pending_bytes.push_back(r.want);
        else
            expand_code(r.code);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (pending_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual %0h %0b %0b %0d",
                         $time, out_byte, has_byte, last, status);
            end
            else
            begin
                due = pending_bytes.pop_front();
                check_field("out_byte", 32'(due.data), 32'(out_byte));
                check_field("has_byte", 32'(due.has_data), 32'(has_byte));
                check_field("last", 32'(due.is_last), 32'(last));
                check_field("status", 32'(due.st), 32'(status));
            end
        end
    end

    // counts cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("** bpe_dictionary_expander: FAILED **");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        stim_row_t row;
        int        counted;
        counted = 0;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            dict_used[i] = 1'b0;
            dict[i]      = '0;
        end

        plan.push_back(expand_row(8'd0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}));
        plan.push_back(expand_row(8'd240, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TERM}));
        plan.push_back(expand_row(8'd255, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TERM}));
        // loads outside the table are dropped
        plan.push_back(load_row(8'd255, 1'b0, 3'd4, 32'h1234_5678));
        plan.push_back(load_row(8'd240, 1'b1, 3'd7, 32'hFFFF_0000));
        plan.push_back(load_row(8'd0, 1'b0, 3'd0, 32'hFFFF_FFFF));
        plan.push_back(expand_row(8'd0, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK}));
        plan.push_back(load_row(8'd1, 1'b0, 3'd7, 32'h4433_2211));
        plan.push_back(expand_row(8'd1, 1'b0, '0));
        plan.push_back(load_row(8'd239, 1'b0, 3'd1, 32'hFFFF_FFA5));
        plan.push_back(expand_row(8'd239, 1'b1, '{8'hA5, 1'b1, 1'b1, ST_OK}));
        plan.push_back(load_row(8'd2, 1'b1, 3'd7, 32'hFFFF_01EF));
        plan.push_back(expand_row(8'd2, 1'b0, '0));
        // doubling chain: 8, 16, 32, 64 bytes, then 68 bytes, past the cap
        plan.push_back(load_row(8'd4, 1'b1, 3'd0, 32'h0000_0101));
        plan.push_back(load_row(8'd5, 1'b1, 3'd0, 32'h0000_0404));
        plan.push_back(load_row(8'd6, 1'b1, 3'd0, 32'h0000_0505));
        plan.push_back(load_row(8'd7, 1'b1, 3'd0, 32'h0000_0606));
        plan.push_back(load_row(8'd8, 1'b1, 3'd0, 32'h0000_0107));
        plan.push_back(expand_row(8'd7, 1'b0, '0));
        plan.push_back(expand_row(8'd8, 1'b0, '0));
        // left recursion fills the stack
        plan.push_back(load_row(8'd9, 1'b1, 3'd0, 32'h0000_0909));
        plan.push_back(expand_row(8'd9, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OVF}));
        plan.push_back(load_row(8'd11, 1'b1, 3'd0, 32'h0000_0901));
        plan.push_back(expand_row(8'd11, 1'b0, '0));
        // right recursion through a terminator: bounded stack, hits the walk limit
        plan.push_back(load_row(8'd12, 1'b1, 3'd0, 32'h0000_0CF1));
        plan.push_back(expand_row(8'd12, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OVF}));
        plan.push_back(load_row(8'd13, 1'b1, 3'd0, 32'h0000_EFC8));
        plan.push_back(expand_row(8'd13, 1'b0, '0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            maybe_idle();
            issue(plan[i]);
        end

        while (counted < RANDOM_ITEMS)
        begin
            if (counted < 40 || counted > 70)
                maybe_idle();
            row = random_row();
            issue(row);
            if (row.act == ACT_EXPAND || row.code < NUM_CODES)
                counted++;
        end
        start <= 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("** bpe_dictionary_expander: PASSED **");
        else
            $display("** bpe_dictionary_expander: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bpe_pkg.sv
src/bpe_ram.sv
src/bpe_ctrl.sv
src/bpe_datapath.sv
src/bpe_dictionary_expander.sv
tb/sv/tb_bpe_dictionary_expander.sv
